>>> hdl/sld_pkg.sv
// ----------------------------------------------------------------------------
// Sync/length deframer package
// Shared types, register codes and reset constants for the deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int SKIP_W = 4;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Largest number of extra header bytes the skip counter can hold.
    localparam int EXTRA_HEADER_MAX = (1 << SKIP_W) - 1;
    localparam int EXTRA_HEADER_DEF = 0;

    localparam logic [LEN_W-1:0]  SYNC_WORD_RST   = 16'hAA33;
    localparam logic [BYTE_W-1:0] CHECK_VALUE_RST = 8'h00;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_OK      = 2'd1,
        KIND_FAIL    = 2'd2,
        KIND_ZERO    = 2'd3
    } t_kind;

    typedef enum logic [0:0] {
        REG_SYNC_WORD   = 1'b0,
        REG_CHECK_VALUE = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [LEN_W-1:0]  sync_word;
        logic [BYTE_W-1:0] check_value;
    } t_cfg;

endpackage

>>> hdl/sld_stream_if.sv
// ----------------------------------------------------------------------------
// Deframer stream interfaces
// Valid/ready channels for received bytes and for deframer results.
// ----------------------------------------------------------------------------
interface sld_byte_if import sld_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface sld_result_if import sld_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    t_kind             kind;

    modport source (output valid, output out_byte, output kind, input ready);
    modport sink   (input valid, input out_byte, input kind, output ready);
endinterface

>>> hdl/sync_length_frame_deframer.sv
// ----------------------------------------------------------------------------
// Sync word / length prefixed frame deframer
// Hunts for a 16-bit sync word in a byte stream, reads a 16-bit length,
// skips optional header bytes, emits the body and checks the final byte.
//
// Usage:
//   i_in  : one received byte per transaction (valid/ready).
//   o_out : results; kind payload carries a body byte, the other kinds
//           report frame end with check ok, check failed, or a rejected
//           zero-length frame. Bytes that cause no result produce nothing.
//   APB   : register 0 at address 0 is the sync word (high byte first on
//           the line), register 1 at address 4 is the check value.
// Timing: a byte is held in the input register until the parser steps and
//   is then parsed into the result register, from which the result is
//   presented. One byte is taken every cycle while results are taken;
//   the frame state machine is the only loop.
// Reset: the parser returns to hunting the first sync byte, both
//   registers take their default values and no result is pending.
// Stall: while a result is not taken the input register keeps one byte;
//   i_in.ready drops once that register is also full.
// Registers should only be written while the block is idle.
// ----------------------------------------------------------------------------
module sync_length_frame_deframer import sld_pkg::*; #(
    parameter int EXTRA_HEADER_BYTES = EXTRA_HEADER_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sld_byte_if.sink          i_in,
    sld_result_if.source      o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg              cfg;
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              step_ok;
    logic              consume;
    logic              accept;

    sld_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign consume    = r_in_vld && step_ok;
    assign i_in.ready = !r_in_vld || step_ok;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (consume) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    sld_parser #(
        .EXTRA_HEADER_BYTES (EXTRA_HEADER_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_vld       (r_in_vld),
        .i_byte      (r_in_byte),
        .o_step_ok   (step_ok),
        .i_out_ready (o_out.ready),
        .o_out_vld   (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_out_kind  (o_out.kind)
    );

endmodule

>>> hdl/sld_apb_regs.sv
// ----------------------------------------------------------------------------
// Deframer configuration registers
// APB-style register file holding the sync word and the check value.
// ----------------------------------------------------------------------------
module sld_apb_regs import sld_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_word   <= SYNC_WORD_RST;
            r_cfg.check_value <= CHECK_VALUE_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SYNC_WORD:   r_cfg.sync_word   <= pwdata[LEN_W-1:0];
                REG_CHECK_VALUE: r_cfg.check_value <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SYNC_WORD:   prdata = DATA_W'(r_cfg.sync_word);
            REG_CHECK_VALUE: prdata = DATA_W'(r_cfg.check_value);
            default:         prdata = '0;
        endcase
    end

endmodule

>>> hdl/sld_parser.sv
// ----------------------------------------------------------------------------
// Deframer parser
// Frame state machine with the result register behind it; one byte a step.
// ----------------------------------------------------------------------------
module sld_parser import sld_pkg::*; #(
    parameter int EXTRA_HEADER_BYTES = EXTRA_HEADER_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_vld,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_step_ok,
    input  logic              i_out_ready,
    output logic              o_out_vld,
    output logic [BYTE_W-1:0] o_out_byte,
    output t_kind             o_out_kind
);

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LENHI = 3'd2,
        PH_LENLO = 3'd3,
        PH_SKIP  = 3'd4,
        PH_BODY  = 3'd5
    } t_phase;

    localparam logic [SKIP_W-1:0] SKIP_INIT = SKIP_W'(EXTRA_HEADER_BYTES);

    t_phase            r_phase,       n_phase;
    logic [BYTE_W-1:0] r_length_high, n_length_high;
    logic [LEN_W-1:0]  r_bytes_left,  n_bytes_left;
    logic [SKIP_W-1:0] r_skip_left,   n_skip_left;
    logic              r_out_vld;
    logic [BYTE_W-1:0] r_out_byte;
    t_kind             r_out_kind;

    logic              step;
    logic              emit;
    logic [BYTE_W-1:0] emit_byte;
    t_kind             emit_kind;
    logic [BYTE_W-1:0] sync_hi;
    logic [BYTE_W-1:0] sync_lo;
    logic [LEN_W-1:0]  length;

    assign sync_hi   = i_cfg.sync_word[LEN_W-1:BYTE_W];
    assign sync_lo   = i_cfg.sync_word[BYTE_W-1:0];
    assign length    = {r_length_high, i_byte};
    assign o_step_ok = !r_out_vld || i_out_ready;
    assign step      = i_vld && o_step_ok;

    always_comb begin
        n_phase       = r_phase;
        n_length_high = r_length_high;
        n_bytes_left  = r_bytes_left;
        n_skip_left   = r_skip_left;
        emit          = 1'b0;
        emit_byte     = '0;
        emit_kind     = KIND_PAYLOAD;
        unique case (r_phase)
            PH_SYNC2: begin
                if (i_byte == sync_lo) begin
                    n_phase = PH_LENHI;
                end else if (i_byte == sync_hi) begin
                    n_phase = PH_SYNC2;
                end else begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_LENHI: begin
                n_length_high = i_byte;
                n_phase       = PH_LENLO;
            end
            PH_LENLO: begin
                n_bytes_left = length;
                n_skip_left  = SKIP_INIT;
                if (length == '0) begin
                    emit      = 1'b1;
                    emit_kind = KIND_ZERO;
                end
                if (SKIP_INIT != '0) begin
                    n_phase = PH_SKIP;
                end else if (length == '0) begin
                    n_phase = PH_SYNC1;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_SKIP: begin
                if (r_skip_left != '0) begin
                    n_skip_left = r_skip_left - 1'b1;
                end
                if (n_skip_left == '0) begin
                    n_phase = (r_bytes_left == '0) ? PH_SYNC1 : PH_BODY;
                end
            end
            PH_BODY: begin
                emit = 1'b1;
                if (r_bytes_left <= LEN_W'(1)) begin
                    n_bytes_left = '0;
                    n_phase      = PH_SYNC1;
                    emit_kind    = (i_byte == i_cfg.check_value) ? KIND_OK : KIND_FAIL;
                end else begin
                    n_bytes_left = r_bytes_left - 1'b1;
                    emit_byte    = i_byte;
                end
            end
            default: begin
                n_phase = (i_byte == sync_hi) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SYNC1;
            r_length_high <= '0;
            r_bytes_left  <= '0;
            r_skip_left   <= '0;
            r_out_vld     <= 1'b0;
        end else if (step) begin
            r_phase       <= n_phase;
            r_length_high <= n_length_high;
            r_bytes_left  <= n_bytes_left;
            r_skip_left   <= n_skip_left;
            r_out_vld     <= emit;
        end else if (i_out_ready) begin
            r_out_vld     <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_byte <= emit_byte;
            r_out_kind <= emit_kind;
        end
    end

    assign o_out_vld  = r_out_vld;
    assign o_out_byte = r_out_byte;
    assign o_out_kind = r_out_kind;

    // The body count never runs out while the body is being read.
    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> r_bytes_left != '0)
        else $error("body phase with no bytes left");

    // Skipping always has at least one header byte still to drop.
    a_skip_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SKIP |-> r_skip_left != '0)
        else $error("skip phase with empty skip counter");

    // A check byte ends the frame and returns the hunt to the first sync byte.
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_phase == PH_BODY && r_bytes_left <= LEN_W'(1)
        |=> r_phase == PH_SYNC1 && r_out_vld && r_out_kind != KIND_PAYLOAD)
        else $error("frame end not reported");

    // Only payload results carry a data byte.
    a_kind_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_kind != KIND_PAYLOAD |-> r_out_byte == '0)
        else $error("non-payload result with non-zero byte");

endmodule
